FILE: rtl/core/pcdf_pkg.sv
// ----------------------------------------------------------------------------
// pcdf_pkg
// Shared types and constants for the dithered, fading PWM channel.
// ----------------------------------------------------------------------------
package pcdf_pkg;

  localparam int unsigned COUNTER_BITS_DEF = 20;
  localparam int unsigned DITHER_STEPS_DEF = 16;

  localparam int unsigned PERIOD_W   = 21;
  localparam int unsigned HSTART_W   = 20;
  localparam int unsigned DUTYVAL_W  = 25;
  localparam int unsigned FRAC_W     = 4;
  localparam int unsigned DUTY_W     = 21;
  localparam int unsigned FADE_W     = 10;
  localparam int unsigned STEP_W     = 11;
  localparam int unsigned OFFSET_W   = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;

  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 21'h100000;
  localparam logic [FADE_W-1:0]   FADE_CYCLE_RST = 10'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_LIMIT = 3'd0,
    CFG_HIGH_START   = 3'd1,
    CFG_DUTY_VALUE   = 3'd2,
    CFG_OUT_ENABLE   = 3'd3,
    CFG_IDLE_LEVEL   = 3'd4,
    CFG_FADE_COUNT   = 3'd5,
    CFG_FADE_CYCLE   = 3'd6,
    CFG_FADE_STEP    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [PERIOD_W-1:0]  period_limit;
    logic [HSTART_W-1:0]  high_start;
    logic [DUTYVAL_W-1:0] duty_value;
    logic                 out_enable;
    logic                 idle_level;
    logic [FADE_W-1:0]    fade_count;
    logic [FADE_W-1:0]    fade_cycle;
    logic [STEP_W-1:0]    fade_step;
  } cfg_t;

  // per-transaction control from the timer into the fade/dither unit
  typedef struct packed {
    logic accept;
    logic restart;
    logic wrap;
  } fade_ctrl_t;

endpackage

FILE: rtl/core/pcdf_tick_if.sv
// ----------------------------------------------------------------------------
// pcdf_tick_if
// Tick channel: timer reset, pause and restart flags with valid/ready.
// ----------------------------------------------------------------------------
interface pcdf_tick_if;
  logic valid;
  logic ready;
  logic timer_reset;
  logic timer_pause;
  logic restart;

  modport source (output valid, output timer_reset, output timer_pause,
                  output restart, input ready);
  modport sink   (input valid, input timer_reset, input timer_pause,
                  input restart, output ready);
endinterface

FILE: rtl/core/pcdf_res_if.sv
// ----------------------------------------------------------------------------
// pcdf_res_if
// Result channel: PWM level, counter, duty and period flags with valid/ready.
// ----------------------------------------------------------------------------
interface pcdf_res_if #(
  parameter int unsigned COUNTER_BITS = pcdf_pkg::COUNTER_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            pwm_level;
  logic [COUNTER_BITS-1:0]         count_value;
  logic [pcdf_pkg::DUTY_W-1:0]     duty_now;
  logic                            period_wrap;
  logic                            fade_done;

  modport source (output valid, output pwm_level, output count_value,
                  output duty_now, output period_wrap, output fade_done,
                  input ready);
  modport sink   (input valid, input pwm_level, input count_value,
                  input duty_now, input period_wrap, input fade_done,
                  output ready);
endinterface

FILE: rtl/core/pcdf_fade.sv
// ----------------------------------------------------------------------------
// pcdf_fade
// Dither index, fade stepping and effective duty computation.
// ----------------------------------------------------------------------------
module pcdf_fade #(
  parameter int unsigned DITHER_STEPS = pcdf_pkg::DITHER_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcdf_pkg::cfg_t              cfg_i,
  input  pcdf_pkg::fade_ctrl_t        ctrl_i,
  output logic [pcdf_pkg::DUTY_W-1:0] duty_o,   // duty after this transaction
  output logic                        done_o
);

  localparam int unsigned IW = $clog2(DITHER_STEPS);
  localparam logic [IW-1:0] IDX_LAST = IW'(DITHER_STEPS - 1);

  logic [IW-1:0]                   idx_q, idx_d;
  logic [pcdf_pkg::FADE_W-1:0]     left_q, left_d;
  logic [pcdf_pkg::FADE_W-1:0]     wait_q, wait_d;
  logic [pcdf_pkg::OFFSET_W-1:0]   off_q, off_d;
  logic [pcdf_pkg::DUTY_W-1:0]     duty_q, duty_d;
  logic [pcdf_pkg::OFFSET_W-1:0]   step_ext;
  logic [pcdf_pkg::DUTY_W-1:0]     base;
  logic [pcdf_pkg::FRAC_W-1:0]     frac;
  logic                            recompute;

  assign step_ext = {{(pcdf_pkg::OFFSET_W - pcdf_pkg::STEP_W)
                      {cfg_i.fade_step[pcdf_pkg::STEP_W-1]}}, cfg_i.fade_step};
  assign base = cfg_i.duty_value[pcdf_pkg::DUTYVAL_W-1:pcdf_pkg::FRAC_W];
  assign frac = cfg_i.duty_value[pcdf_pkg::FRAC_W-1:0];

  always_comb begin
    idx_d     = idx_q;
    left_d    = left_q;
    wait_d    = wait_q;
    off_d     = off_q;
    done_o    = 1'b0;
    recompute = 1'b0;
    if (ctrl_i.restart) begin
      idx_d     = '0;
      left_d    = cfg_i.fade_count;
      wait_d    = cfg_i.fade_cycle;
      off_d     = '0;
      recompute = 1'b1;
    end else if (ctrl_i.wrap) begin
      idx_d     = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
      recompute = 1'b1;
      if (left_q != '0) begin
        // a wait of zero or one both mean the step is due now
        if (wait_q <= pcdf_pkg::FADE_W'(1)) begin
          off_d  = off_q + step_ext;
          wait_d = cfg_i.fade_cycle;
          left_d = left_q - 1'b1;
          done_o = (left_d == '0);
        end else begin
          wait_d = wait_q - 1'b1;
        end
      end
    end
  end

  // low 21 bits of base + dither bit + sign-extended offset
  always_comb begin
    duty_d = duty_q;
    if (recompute) begin
      duty_d = base + pcdf_pkg::DUTY_W'(frac > pcdf_pkg::FRAC_W'(idx_d))
             + off_d[pcdf_pkg::DUTY_W-1:0];
    end
  end

  assign duty_o = duty_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      left_q <= '0;
      wait_q <= '0;
      off_q  <= '0;
      duty_q <= '0;
    end else if (ctrl_i.accept) begin
      idx_q  <= idx_d;
      left_q <= left_d;
      wait_q <= wait_d;
      off_q  <= off_d;
      duty_q <= duty_d;
    end
  end

endmodule

FILE: rtl/core/pwm_channel_dither_fade.sv
// ----------------------------------------------------------------------------
// pwm_channel_dither_fade
// One PWM channel with its timer, fractional duty dither and linear fade.
// ----------------------------------------------------------------------------
// Latency: a result is valid in the cycle after its tick transaction.
// Throughput: one tick per cycle; the output register takes a new result
//   whenever the previous one is being taken or is absent.
// The critical path is counter increment, duty add and the window compare.
// Reset: rst_ni clears counter, dither and fade state and loads register
//   defaults (period 2^20, fade cycle 1, everything else zero).
module pwm_channel_dither_fade #(
  parameter int unsigned COUNTER_BITS = pcdf_pkg::COUNTER_BITS_DEF,
  parameter int unsigned DITHER_STEPS = pcdf_pkg::DITHER_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcdf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcdf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  pcdf_tick_if.sink                       tick_i,
  pcdf_res_if.source                      res_o
);

  localparam int unsigned CW = ((COUNTER_BITS > pcdf_pkg::PERIOD_W) ?
                                COUNTER_BITS : pcdf_pkg::PERIOD_W) + 1;
  localparam int unsigned KW = ((COUNTER_BITS > pcdf_pkg::OFFSET_W) ?
                                COUNTER_BITS : pcdf_pkg::OFFSET_W) + 1;
  localparam logic [CW-1:0] LIM_MAX = CW'(64'd1 << COUNTER_BITS);

  pcdf_pkg::cfg_t             cfg_q;
  pcdf_pkg::fade_ctrl_t       fctrl;
  logic                       accept;
  logic [COUNTER_BITS-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]              lim, cnt_inc;
  logic                       wrap;
  logic [pcdf_pkg::DUTY_W-1:0] duty;
  logic                       done;
  logic [KW-1:0]              cnt_k, hs_k, end_k;
  logic                       level;

  logic                        res_valid_q;
  logic                        res_level_q;
  logic [COUNTER_BITS-1:0]     res_cnt_q;
  logic [pcdf_pkg::DUTY_W-1:0] res_duty_q;
  logic                        res_wrap_q;
  logic                        res_done_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{period_limit: pcdf_pkg::PERIOD_RST, high_start: '0, duty_value: '0,
                 out_enable: 1'b0, idle_level: 1'b0, fade_count: '0,
                 fade_cycle: pcdf_pkg::FADE_CYCLE_RST, fade_step: '0};
    end else if (cfg_we_i) begin
      case (pcdf_pkg::cfg_idx_e'(cfg_index_i))
        pcdf_pkg::CFG_PERIOD_LIMIT:
          cfg_q.period_limit <= cfg_wdata_i[pcdf_pkg::PERIOD_W-1:0];
        pcdf_pkg::CFG_HIGH_START:
          cfg_q.high_start <= cfg_wdata_i[pcdf_pkg::HSTART_W-1:0];
        pcdf_pkg::CFG_DUTY_VALUE:
          cfg_q.duty_value <= cfg_wdata_i[pcdf_pkg::DUTYVAL_W-1:0];
        pcdf_pkg::CFG_OUT_ENABLE: cfg_q.out_enable <= cfg_wdata_i[0];
        pcdf_pkg::CFG_IDLE_LEVEL: cfg_q.idle_level <= cfg_wdata_i[0];
        pcdf_pkg::CFG_FADE_COUNT:
          cfg_q.fade_count <= cfg_wdata_i[pcdf_pkg::FADE_W-1:0];
        pcdf_pkg::CFG_FADE_CYCLE:
          cfg_q.fade_cycle <= cfg_wdata_i[pcdf_pkg::FADE_W-1:0];
        pcdf_pkg::CFG_FADE_STEP:
          cfg_q.fade_step <= cfg_wdata_i[pcdf_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick_i.ready = !res_valid_q || res_o.ready;
  assign accept       = tick_i.valid && tick_i.ready;

  // effective limit: zero acts as one, capped at the counter range
  always_comb begin
    lim = CW'(cfg_q.period_limit);
    if (lim == '0) lim = CW'(1);
    if (lim > LIM_MAX) lim = LIM_MAX;
  end

  assign cnt_inc = CW'(cnt_q) + CW'(1);

  always_comb begin
    cnt_d = cnt_q;
    wrap  = 1'b0;
    if (tick_i.timer_reset) begin
      cnt_d = '0;
    end else if (!tick_i.timer_pause) begin
      if (cnt_inc < lim) begin
        cnt_d = cnt_inc[COUNTER_BITS-1:0];
      end else begin
        cnt_d = '0;
        wrap  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  assign fctrl.accept  = accept;
  assign fctrl.restart = tick_i.restart;
  assign fctrl.wrap    = wrap;

  pcdf_fade #(
    .DITHER_STEPS(DITHER_STEPS)
  ) u_fade (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .ctrl_i (fctrl),
    .duty_o (duty),
    .done_o (done)
  );

  // high window: high_start <= count < high_start + duty
  assign cnt_k = KW'(cnt_d);
  assign hs_k  = KW'(cfg_q.high_start);
  assign end_k = hs_k + KW'(duty);
  assign level = cfg_q.out_enable ? ((cnt_k >= hs_k) && (cnt_k < end_k))
                                  : cfg_q.idle_level;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (tick_i.ready) begin
      res_valid_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_level_q <= level;
      res_cnt_q   <= cnt_d;
      res_duty_q  <= duty;
      res_wrap_q  <= wrap;
      res_done_q  <= done;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.pwm_level   = res_level_q;
  assign res_o.count_value = res_cnt_q;
  assign res_o.duty_now    = res_duty_q;
  assign res_o.period_wrap = res_wrap_q;
  assign res_o.fade_done   = res_done_q;

  // a fade can only finish on a period wrap
  a_done_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_done_q |-> res_wrap_q)
    else $error("fade_done without period_wrap");

  // a wrap always leaves the counter at zero
  a_wrap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_wrap_q |-> res_cnt_q == '0)
    else $error("period_wrap with nonzero count");

  // timer reset forces a zero count and no wrap in the next result
  a_timer_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && tick_i.timer_reset |=> res_cnt_q == '0 && !res_wrap_q)
    else $error("timer_reset not honored");

  // a counting tick never leaves the counter at or past the effective limit
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !tick_i.timer_pause |-> CW'(cnt_d) < lim)
    else $error("counter beyond period limit");

endmodule

FILE: verif/pwm_channel_dither_fade_tb.sv
// ----------------------------------------------------------------------------
// pwm_channel_dither_fade_tb
// Self-checking bench for the dithered, fading PWM channel. Timer ticks are
// streamed with random pacing while the result side stalls at random; a
// transaction-level model of counter, dither and fade predicts every result
// transaction, and results are compared field by field in order. Several
// register settings are exercised, each loaded while the channel is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pwm_channel_dither_fade_tb;

  localparam int unsigned CNT_W       = pcdf_pkg::COUNTER_BITS_DEF;
  localparam int unsigned TICK_TARGET = 1550;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic timer_reset;
    logic timer_pause;
    logic restart;
    logic hold_for_drain;  // wait for all results before sending
  } tick_item_t;

  typedef struct packed {
    logic                        pwm_level;
    logic [CNT_W-1:0]            count_value;
    logic [pcdf_pkg::DUTY_W-1:0] duty_now;
    logic                        period_wrap;
    logic                        fade_done;
  } pwm_sample_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [pcdf_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [pcdf_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  pcdf_tick_if tick_if ();
  pcdf_res_if  res_if ();

  pwm_channel_dither_fade i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tick_i      (tick_if),
    .res_o       (res_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  tick_item_t  ticks_to_send[$];
  pwm_sample_t pwm_samples_due[$];
  int unsigned ticks_queued;
  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          tick_taken;
  bit          res_taken;
  bit          pace_gaps;
  bit          pace_stalls;

  // channel model: register copy and running state
  pcdf_pkg::cfg_t                  m_cfg;
  logic [CNT_W-1:0]                m_count;
  logic [pcdf_pkg::FRAC_W-1:0]     m_dither;
  logic [pcdf_pkg::FADE_W-1:0]     m_fade_left;
  logic [pcdf_pkg::FADE_W-1:0]     m_fade_wait;
  logic [pcdf_pkg::OFFSET_W-1:0]   m_offset;
  logic [pcdf_pkg::DUTY_W-1:0]     m_duty;

  function automatic logic [pcdf_pkg::DUTY_W-1:0] dithered_duty();
    logic [pcdf_pkg::DUTY_W-1:0] base;
    base = m_cfg.duty_value[pcdf_pkg::DUTYVAL_W-1:pcdf_pkg::FRAC_W];
    if (m_cfg.duty_value[pcdf_pkg::FRAC_W-1:0] > m_dither) base = base + 1'b1;
    // offset is two's complement; only the low DUTY_W bits matter after wrap
    return base + m_offset[pcdf_pkg::DUTY_W-1:0];
  endfunction

  task automatic advance_channel(input tick_item_t t);
    int unsigned lim;
    logic        wrap;
    logic        done;
    logic        level;
    lim  = 32'(m_cfg.period_limit);
    wrap = 1'b0;
    done = 1'b0;
    if (lim == 0) lim = 1;
    if (lim > (32'd1 << CNT_W)) lim = 32'd1 << CNT_W;
    if (t.timer_reset) begin
      m_count = '0;
    end else if (!t.timer_pause) begin
      if (32'(m_count) + 1 < lim) begin
        m_count = m_count + 1'b1;
      end else begin
        m_count = '0;
        wrap    = 1'b1;
      end
    end
    if (t.restart) begin
      m_dither    = '0;
      m_fade_left = m_cfg.fade_count;
      m_fade_wait = m_cfg.fade_cycle;
      m_offset    = '0;
      m_duty      = dithered_duty();
    end else if (wrap) begin
      m_dither = m_dither + 1'b1;
      if (m_fade_left != 0) begin
        if (m_fade_wait <= 1) begin
          m_offset    = m_offset +
                        {{(pcdf_pkg::OFFSET_W-pcdf_pkg::STEP_W)
                          {m_cfg.fade_step[pcdf_pkg::STEP_W-1]}}, m_cfg.fade_step};
          m_fade_wait = m_cfg.fade_cycle;
          m_fade_left = m_fade_left - 1'b1;
          done        = (m_fade_left == 0);
        end else begin
          m_fade_wait = m_fade_wait - 1'b1;
        end
      end
      m_duty = dithered_duty();
    end
    if (m_cfg.out_enable)
      level = (m_count >= m_cfg.high_start) &&
              (32'(m_count) < 32'(m_cfg.high_start) + 32'(m_duty));
    else
      level = m_cfg.idle_level;
    pwm_samples_due.push_back('{level, m_count, m_duty, wrap, done});
  endtask

  function automatic int unsigned draw_pause(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tick_item_t mk_tick(input logic rst, input logic pause,
                                         input logic restart);
    return '{rst, pause, restart, 1'b0};
  endfunction

  // tick source
  always @(negedge clk_i) begin : drive_ticks
    tick_item_t nxt;
    if (rst_ni && (!tick_if.valid || tick_taken)) begin
      if (gap_left != 0) begin
        tick_if.valid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (ticks_to_send.size() != 0 &&
                   !(ticks_to_send[0].hold_for_drain && pwm_samples_due.size() != 0)) begin
        nxt = ticks_to_send.pop_front();
        tick_if.valid       <= 1'b1;
        tick_if.timer_reset <= nxt.timer_reset;
        tick_if.timer_pause <= nxt.timer_pause;
        tick_if.restart     <= nxt.restart;
        gap_left            <= draw_pause(pace_gaps);
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
  end

  // result sink back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        res_if.ready <= 1'b1;
        stall_left   <= draw_pause(pace_stalls);
      end
    end
  end

  always @(posedge clk_i) begin : observe
    pwm_sample_t want;
    tick_taken = rst_ni && tick_if.valid && tick_if.ready;
    res_taken  = rst_ni && res_if.valid && res_if.ready;
    if (rst_ni && cfg_we_i) begin
      case (pcdf_pkg::cfg_idx_e'(cfg_index_i))
        pcdf_pkg::CFG_PERIOD_LIMIT:
          m_cfg.period_limit = cfg_wdata_i[pcdf_pkg::PERIOD_W-1:0];
        pcdf_pkg::CFG_HIGH_START:
          m_cfg.high_start   = cfg_wdata_i[pcdf_pkg::HSTART_W-1:0];
        pcdf_pkg::CFG_DUTY_VALUE:
          m_cfg.duty_value   = cfg_wdata_i[pcdf_pkg::DUTYVAL_W-1:0];
        pcdf_pkg::CFG_OUT_ENABLE: m_cfg.out_enable = cfg_wdata_i[0];
        pcdf_pkg::CFG_IDLE_LEVEL: m_cfg.idle_level = cfg_wdata_i[0];
        pcdf_pkg::CFG_FADE_COUNT:
          m_cfg.fade_count   = cfg_wdata_i[pcdf_pkg::FADE_W-1:0];
        pcdf_pkg::CFG_FADE_CYCLE:
          m_cfg.fade_cycle   = cfg_wdata_i[pcdf_pkg::FADE_W-1:0];
        pcdf_pkg::CFG_FADE_STEP:
          m_cfg.fade_step    = cfg_wdata_i[pcdf_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
    // check before predicting so an early result cannot match its own tick
    if (res_taken) begin
      if (pwm_samples_due.size() == 0) begin
        $error("result transaction with no tick outstanding (count_value %0d)",
               res_if.count_value);
        errors++;
      end else begin
        want = pwm_samples_due.pop_front();
        if (res_if.pwm_level !== want.pwm_level) begin
          $error("pwm_level: expected %0d, actual %0d", want.pwm_level, res_if.pwm_level);
          errors++;
        end
        if (res_if.count_value !== want.count_value) begin
          $error("count_value: expected %0d, actual %0d", want.count_value,
                 res_if.count_value);
          errors++;
        end
        if (res_if.duty_now !== want.duty_now) begin
          $error("duty_now: expected %0d, actual %0d", want.duty_now, res_if.duty_now);
          errors++;
        end
        if (res_if.period_wrap !== want.period_wrap) begin
          $error("period_wrap: expected %0d, actual %0d", want.period_wrap,
                 res_if.period_wrap);
          errors++;
        end
        if (res_if.fade_done !== want.fade_done) begin
          $error("fade_done: expected %0d, actual %0d", want.fade_done, res_if.fade_done);
          errors++;
        end
      end
    end
    if (tick_taken)
      advance_channel(mk_tick(tick_if.timer_reset, tick_if.timer_pause, tick_if.restart));
    if (!rst_ni || tick_taken || res_taken)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic tick_item_t random_tick();
    tick_item_t t;
    t.timer_reset    = ($urandom_range(0, 29) == 0);
    t.timer_pause    = ($urandom_range(0, 7) == 0);
    t.restart        = ($urandom_range(0, 39) == 0);
    t.hold_for_drain = ($urandom_range(0, 199) == 0);
    return t;
  endfunction

  function automatic pcdf_pkg::cfg_t random_setting();
    pcdf_pkg::cfg_t c;
    int unsigned    sel;
    sel = $urandom_range(0, 19);
    if (sel == 0)      c.period_limit = '0;
    else if (sel == 1) c.period_limit = pcdf_pkg::PERIOD_W'($urandom_range(100, 300));
    else if (sel == 2) c.period_limit = pcdf_pkg::PERIOD_W'($urandom);
    else               c.period_limit = pcdf_pkg::PERIOD_W'($urandom_range(1, 24));
    c.high_start = ($urandom_range(0, 9) == 0) ?
                   pcdf_pkg::HSTART_W'($urandom) :
                   pcdf_pkg::HSTART_W'($urandom_range(0, 26));
    if ($urandom_range(0, 9) == 0)
      c.duty_value = pcdf_pkg::DUTYVAL_W'($urandom);
    else
      c.duty_value = {pcdf_pkg::DUTY_W'($urandom_range(0, 28)),
                      pcdf_pkg::FRAC_W'($urandom)};
    c.out_enable = ($urandom_range(0, 3) != 0);
    c.idle_level = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 9);
    c.fade_count = (sel == 0) ? pcdf_pkg::FADE_W'($urandom) :
                   (sel == 1) ? {pcdf_pkg::FADE_W{1'b1}} :
                                pcdf_pkg::FADE_W'($urandom_range(0, 8));
    c.fade_cycle = ($urandom_range(0, 9) == 0) ? pcdf_pkg::FADE_W'($urandom)
                                               : pcdf_pkg::FADE_W'($urandom_range(0, 4));
    c.fade_step  = ($urandom_range(0, 4) == 0) ?
                   pcdf_pkg::STEP_W'($urandom) :
                   pcdf_pkg::STEP_W'($urandom_range(0, 16) - 8);
    return c;
  endfunction

  task automatic write_reg(input pcdf_pkg::cfg_idx_e idx,
                           input logic [pcdf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic load_setting(input pcdf_pkg::cfg_t c);
    write_reg(pcdf_pkg::CFG_PERIOD_LIMIT, pcdf_pkg::CFG_DATA_W'(c.period_limit));
    write_reg(pcdf_pkg::CFG_HIGH_START,   pcdf_pkg::CFG_DATA_W'(c.high_start));
    write_reg(pcdf_pkg::CFG_DUTY_VALUE,   pcdf_pkg::CFG_DATA_W'(c.duty_value));
    write_reg(pcdf_pkg::CFG_OUT_ENABLE,   pcdf_pkg::CFG_DATA_W'(c.out_enable));
    write_reg(pcdf_pkg::CFG_IDLE_LEVEL,   pcdf_pkg::CFG_DATA_W'(c.idle_level));
    write_reg(pcdf_pkg::CFG_FADE_COUNT,   pcdf_pkg::CFG_DATA_W'(c.fade_count));
    write_reg(pcdf_pkg::CFG_FADE_CYCLE,   pcdf_pkg::CFG_DATA_W'(c.fade_cycle));
    write_reg(pcdf_pkg::CFG_FADE_STEP,    pcdf_pkg::CFG_DATA_W'(c.fade_step));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sampled at the rising edge, where the source queue and valid are settled
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (ticks_to_send.size() != 0 || tick_if.valid || pwm_samples_due.size() != 0);
  endtask

  task automatic queue_tick(input tick_item_t t);
    ticks_to_send.push_back(t);
    ticks_queued++;
  endtask

  initial begin : stimulus
    pcdf_pkg::cfg_t c;
    int unsigned    n;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = '0;
    cfg_wdata_i         = '0;
    tick_if.valid       = 1'b0;
    tick_if.timer_reset = 1'b0;
    tick_if.timer_pause = 1'b0;
    tick_if.restart     = 1'b0;
    res_if.ready        = 1'b0;
    m_cfg               = '0;
    m_cfg.period_limit  = pcdf_pkg::PERIOD_RST;
    m_cfg.fade_cycle    = pcdf_pkg::FADE_CYCLE_RST;
    m_count             = '0;
    m_dither            = '0;
    m_fade_left         = '0;
    m_fade_wait         = '0;
    m_offset            = '0;
    m_duty              = '0;
    pace_gaps           = 1'b1;
    pace_stalls         = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: reset beats pause, plain pause, restart alone and with reset
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0));
    queue_tick(mk_tick(1'b1, 1'b1, 1'b0));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b0));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1));
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1));
    wait_quiet();

    // zero limit wraps every tick; zero fade cycle; max duty overflows, then
    // a step of -1023 drives the sum below zero
    c = '{period_limit: '0, high_start: '0, duty_value: {pcdf_pkg::DUTYVAL_W{1'b1}},
          out_enable: 1'b1, idle_level: 1'b0, fade_count: 10'd2, fade_cycle: '0,
          fade_step: 11'h401};
    load_setting(c);
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1));
    repeat (3) queue_tick(mk_tick(1'b0, 1'b0, 1'b0));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1));  // restart wins over the wrap
    queue_tick(mk_tick(1'b0, 1'b1, 1'b0));
    queue_tick(mk_tick(1'b1, 1'b0, 1'b0));
    wait_quiet();

    // short period with dither fraction, max fade count, cycle and step
    c = '{period_limit: 21'd4, high_start: 20'd1, duty_value: {21'd2, 4'd5},
          out_enable: 1'b1, idle_level: 1'b1, fade_count: {pcdf_pkg::FADE_W{1'b1}},
          fade_cycle: {pcdf_pkg::FADE_W{1'b1}}, fade_step: 11'h3FF};
    load_setting(c);
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1));
    repeat (4) queue_tick(mk_tick(1'b0, 1'b0, 1'b0));
    // sender holds until every outstanding result has drained
    queue_tick('{1'b0, 1'b0, 1'b0, 1'b1});
    repeat (3) queue_tick(mk_tick(1'b0, 1'b0, 1'b0));
    wait_quiet();

    // limit beyond the counter range, output disabled, top of high_start
    c = '{period_limit: {pcdf_pkg::PERIOD_W{1'b1}}, high_start: {pcdf_pkg::HSTART_W{1'b1}},
          duty_value: '0, out_enable: 1'b0, idle_level: 1'b1, fade_count: 10'd1,
          fade_cycle: 10'd1, fade_step: {pcdf_pkg::STEP_W{1'b1}}};
    load_setting(c);
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1));
    repeat (2) queue_tick(mk_tick(1'b0, 1'b0, 1'b0));
    wait_quiet();

    ticks_queued = 0;
    while (ticks_queued < TICK_TARGET) begin
      load_setting(random_setting());
      pace_gaps   = ($urandom_range(0, 3) != 0);
      pace_stalls = ($urandom_range(0, 3) != 0);
      n = $urandom_range(30, 110);
      // a well-formed run starts by loading the new setting
      queue_tick(mk_tick(1'b0, 1'b0, 1'b1));
      repeat (n) queue_tick(random_tick());
      wait_quiet();
    end

    repeat (4) @(posedge clk_i);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
